[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define PFD_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PFD_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFD_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pfd_pkg.sv]
package pfd_pkg;

    // Window geometry
    localparam int WINDOW_LEN = 10;
    localparam int WIN_AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int COUNT_W    = $clog2(WINDOW_LEN + 1);

    // Field widths
    localparam int ERR_W   = 16;
    localparam int SUM_W   = 20;
    localparam int STAMP_W = 32;
    localparam int ACC_W   = 32;
    localparam int TRIM_W  = 16;

    // Fixed constants
    localparam logic [TRIM_W-1:0] TRIM_MID      = 16'h8000;
    localparam logic [7:0]        COUNTDOWN_RST = 8'd100;
    localparam logic [SUM_W-1:0]  GRADE_BEST    = 20'd10;
    localparam logic [SUM_W-1:0]  GRADE_BETTER  = 20'd50;
    localparam logic [SUM_W-1:0]  GRADE_GOOD    = 20'd500;

    // Unsigned 32-bit divide by 100: (n * magic) >> 37
    localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
    localparam int          DIV100_SHIFT = 37;
    localparam int          PROD_W       = 63;

    // Config port
    localparam int CFG_AW = 5;

    // Event kinds
    localparam logic FUNC_PPS = 1'b0;
    localparam logic FUNC_FIX = 1'b1;

    // Lock grades
    localparam logic [1:0] LOCK_BAD    = 2'd0;
    localparam logic [1:0] LOCK_GOOD   = 2'd1;
    localparam logic [1:0] LOCK_BETTER = 2'd2;
    localparam logic [1:0] LOCK_BEST   = 2'd3;

    typedef enum logic [2:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_SPAN_LEN,
        REG_OSC_COUNTS,
        REG_INITIAL_TRIM
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_MULT,
        S_ACC,
        S_ABS,
        S_DIV,
        S_TRIM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                 func;
        logic [STAMP_W-1:0]   timestamp;
        logic                 fix_valid;
    } t_in_item;

    typedef struct packed {
        logic                     dac_write;
        logic [TRIM_W-1:0]        dac_value;
        logic [1:0]               lock_level;
        logic                     fix_status;
        logic signed [SUM_W-1:0]  window_drift;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  prop_gain;
        logic [9:0]  integ_gain;
        logic [7:0]  span_len;
        logic [23:0] osc_counts;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [TRIM_W-1:0] value;
    } t_trim_load;

    typedef struct packed {
        logic              re;
        logic [WIN_AW-1:0] raddr;
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [ERR_W-1:0]  wdata;
    } t_win_req;

endpackage

[rtl/pfd_win_ram.sv]
module pfd_win_ram (
    input  logic                      i_clk,
    input  pfd_pkg::t_win_req         i_req,
    output logic [pfd_pkg::ERR_W-1:0] o_rdata
);
    import pfd_pkg::*;

    logic [ERR_W-1:0] mem [WINDOW_LEN];
    logic [ERR_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pfd_cfg.sv]
module pfd_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pfd_pkg::t_cfg              o_cfg,
    output pfd_pkg::t_trim_load        o_trim_load
);
    import pfd_pkg::*;

    logic [9:0]        r_prop_gain;
    logic [9:0]        r_integ_gain;
    logic [7:0]        r_span_len;
    logic [23:0]       r_osc_counts;
    logic [TRIM_W-1:0] r_initial_trim;
    logic [2:0]        w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= 10'd150;
            r_integ_gain   <= 10'd10;
            r_span_len     <= 8'd100;
            r_osc_counts   <= 24'd10000000;
            r_initial_trim <= TRIM_MID;
        end else if (w_wr) begin
            case (w_idx)
                REG_PROP_GAIN:    r_prop_gain    <= pwdata[9:0];
                REG_INTEG_GAIN:   r_integ_gain   <= pwdata[9:0];
                REG_SPAN_LEN:     r_span_len     <= pwdata[7:0];
                REG_OSC_COUNTS:   r_osc_counts   <= pwdata[23:0];
                REG_INITIAL_TRIM: r_initial_trim <= pwdata[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            REG_PROP_GAIN:    prdata = {22'd0, r_prop_gain};
            REG_INTEG_GAIN:   prdata = {22'd0, r_integ_gain};
            REG_SPAN_LEN:     prdata = {24'd0, r_span_len};
            REG_OSC_COUNTS:   prdata = {8'd0, r_osc_counts};
            REG_INITIAL_TRIM: prdata = {16'd0, r_initial_trim};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.prop_gain  = r_prop_gain;
    assign o_cfg.integ_gain = r_integ_gain;
    assign o_cfg.span_len   = r_span_len;
    assign o_cfg.osc_counts = r_osc_counts;

    // Writing the initial trim reloads the trim state in the loop
    assign o_trim_load.load  = w_wr && (w_idx == REG_INITIAL_TRIM);
    assign o_trim_load.value = pwdata[TRIM_W-1:0];

endmodule

[rtl/pfd_ctrl.sv]
`include "assert_macros.svh"

module pfd_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfd_pkg::t_cfg             i_cfg,
    input  pfd_pkg::t_trim_load       i_trim_load,
    input  logic                      i_in_valid,
    input  pfd_pkg::t_in_item         i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output pfd_pkg::t_out_item        o_out_data,
    input  logic                      i_out_stall,
    output pfd_pkg::t_win_req         o_win_req,
    input  logic [pfd_pkg::ERR_W-1:0] i_win_rdata
);
    import pfd_pkg::*;

    // Control state
    t_state                  r_state, n_state;
    logic                    r_fix;
    logic [7:0]              r_countdown;
    logic [STAMP_W-1:0]      r_last;
    logic                    r_primed;
    logic [COUNT_W-1:0]      r_count;
    logic [WIN_AW-1:0]       r_wr_ptr;
    logic signed [SUM_W-1:0] r_sum;
    logic [ACC_W-1:0]        r_integral;
    logic [ACC_W-1:0]        r_trim_accum;
    logic [1:0]              r_lock;
    logic [TRIM_W-1:0]       r_trim;
    logic                    r_wrote;
    logic                    r_out_valid;

    // Payload
    t_in_item                r_item;
    logic [ERR_W-1:0]        r_expect;
    logic signed [ERR_W-1:0] r_delta;
    logic [ACC_W-1:0]        r_pterm;
    logic [ACC_W-1:0]        r_iterm;
    logic                    r_neg;
    logic [ACC_W-1:0]        r_mag;
    logic [PROD_W-1:0]       r_prod;
    t_out_item               r_out_data;

    // Combinational
    logic                    w_in_fire;
    logic                    w_out_free;
    logic                    w_out_load;
    logic [7:0]              w_cd_dec;
    logic                    w_sample;
    logic signed [ERR_W-1:0] w_delta;
    logic                    w_full;
    logic signed [SUM_W:0]   w_sum_next;
    logic [SUM_W-1:0]        w_sum_abs;
    logic signed [26:0]      w_pterm;
    logic signed [16:0]      w_trim_off;
    logic [ACC_W-1:0]        w_accum_load;
    logic [ACC_W-1:0]        w_accum_next;
    logic [PROD_W-DIV100_SHIFT-1:0] w_quot;
    logic [TRIM_W-1:0]       w_q16;

    assign w_in_fire  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cd_dec   = r_countdown - 8'd1;
    assign w_sample   = (i_in_data.func == FUNC_PPS) && r_fix && (w_cd_dec == 8'd0);
    assign w_full     = (r_count == COUNT_W'(WINDOW_LEN));

    // Frequency error: counts in the span minus the expected count, low 16 bits
    assign w_delta = ERR_W'(r_item.timestamp - r_last) - r_expect;

    // Running window sum: add newest, drop oldest once full
    assign w_sum_next = {r_sum[SUM_W-1], r_sum}
                      + {{(SUM_W+1-ERR_W){w_delta[ERR_W-1]}}, w_delta}
                      - (w_full ? {{(SUM_W+1-ERR_W){i_win_rdata[ERR_W-1]}}, i_win_rdata}
                                : {(SUM_W+1){1'b0}});
    assign w_sum_abs  = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;

    assign w_pterm      = r_delta * $signed({1'b0, i_cfg.prop_gain});
    assign w_accum_next = r_trim_accum + r_pterm + r_iterm;

    // Initial trim reload: accumulator holds offset times 100
    assign w_trim_off   = $signed({1'b0, i_trim_load.value}) - $signed({1'b0, TRIM_MID});
    assign w_accum_load = {{(ACC_W-17){w_trim_off[16]}}, w_trim_off} * 32'd100;

    assign w_quot = r_prod[PROD_W-1:DIV100_SHIFT];
    assign w_q16  = w_quot[TRIM_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = w_sample ? S_DELTA : S_EMIT;
                end
            end
            S_DELTA: n_state = r_primed ? S_MULT : S_EMIT;
            S_MULT:  n_state = S_ACC;
            S_ACC:   n_state = S_ABS;
            S_ABS:   n_state = S_DIV;
            S_DIV:   n_state = S_TRIM;
            S_TRIM:  n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        w_out_load      = (r_state == S_EMIT) && w_out_free;
        // oldest entry sits where the next write goes
        o_win_req.re    = i_in_valid && (r_state == S_IDLE);
        o_win_req.raddr = r_wr_ptr;
        o_win_req.we    = (r_state == S_DELTA) && r_primed;
        o_win_req.waddr = r_wr_ptr;
        o_win_req.wdata = w_delta;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fix        <= 1'b0;
            r_countdown  <= COUNTDOWN_RST;
            r_last       <= '0;
            r_primed     <= 1'b0;
            r_count      <= '0;
            r_wr_ptr     <= '0;
            r_sum        <= '0;
            r_integral   <= '0;
            r_trim_accum <= '0;
            r_lock       <= LOCK_BAD;
            r_trim       <= TRIM_MID;
            r_wrote      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_neg        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_trim_load.load) begin
                r_trim       <= i_trim_load.value;
                r_trim_accum <= w_accum_load;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_wrote <= 1'b0;
                        if (i_in_data.func == FUNC_FIX) begin
                            if (i_in_data.fix_valid != r_fix) begin
                                r_fix <= i_in_data.fix_valid;
                                // fix lost: restart the window, the integral and the lock grade
                                if (!i_in_data.fix_valid) begin
                                    r_primed    <= 1'b0;
                                    r_count     <= '0;
                                    r_wr_ptr    <= '0;
                                    r_sum       <= '0;
                                    r_countdown <= i_cfg.span_len;
                                    r_integral  <= '0;
                                    r_lock      <= LOCK_BAD;
                                end
                            end
                        end else if (!r_fix) begin
                            r_last <= i_in_data.timestamp;
                        end else if (w_cd_dec != 8'd0) begin
                            r_countdown <= w_cd_dec;
                        end else begin
                            r_countdown <= i_cfg.span_len;
                        end
                    end
                end
                S_DELTA: begin
                    r_last <= r_item.timestamp;
                    if (!r_primed) begin
                        // first sample after fix is skipped
                        r_primed <= 1'b1;
                        r_lock   <= LOCK_BAD;
                    end else begin
                        r_sum      <= w_sum_next[SUM_W-1:0];
                        r_integral <= r_integral
                                    + {{(ACC_W-ERR_W){w_delta[ERR_W-1]}}, w_delta};
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (r_wr_ptr == WIN_AW'(WINDOW_LEN - 1)) begin
                            r_wr_ptr <= '0;
                        end else begin
                            r_wr_ptr <= r_wr_ptr + 1'b1;
                        end
                    end
                end
                S_MULT: begin
                    // lock grade from the new window sum
                    if (!w_full) begin
                        r_lock <= LOCK_BAD;
                    end else if (w_sum_abs < GRADE_BEST) begin
                        r_lock <= LOCK_BEST;
                    end else if (w_sum_abs < GRADE_BETTER) begin
                        r_lock <= LOCK_BETTER;
                    end else if (w_sum_abs < GRADE_GOOD) begin
                        r_lock <= LOCK_GOOD;
                    end else begin
                        r_lock <= LOCK_BAD;
                    end
                end
                S_ACC: r_trim_accum <= w_accum_next;
                S_ABS: r_neg <= r_trim_accum[ACC_W-1];
                S_TRIM: begin
                    // truncate toward zero, center on mid-scale
                    r_trim  <= (r_neg ? (~w_q16 + 1'b1) : w_q16) + TRIM_MID;
                    r_wrote <= 1'b1;
                end
                default: ;
            endcase

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_fire) begin
            r_item   <= i_in_data;
            r_expect <= ERR_W'(i_cfg.span_len * i_cfg.osc_counts[ERR_W-1:0]);
        end
        if (r_state == S_DELTA) begin
            r_delta <= w_delta;
        end
        if (r_state == S_MULT) begin
            r_pterm <= {{(ACC_W-27){w_pterm[26]}}, w_pterm};
            r_iterm <= r_integral * {22'd0, i_cfg.integ_gain};
        end
        if (r_state == S_ABS) begin
            r_mag <= r_trim_accum[ACC_W-1] ? (~r_trim_accum + 1'b1) : r_trim_accum;
        end
        if (r_state == S_DIV) begin
            r_prod <= {31'd0, r_mag} * {32'd0, DIV100_MAGIC};
        end
        if (w_out_load) begin
            r_out_data.dac_write    <= r_wrote;
            r_out_data.dac_value    <= r_trim;
            r_out_data.lock_level   <= r_lock;
            r_out_data.fix_status   <= r_fix;
            r_out_data.window_drift <= r_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `PFD_CHECK(a_count_range, r_count <= COUNT_W'(WINDOW_LEN), "window count past length")
    `PFD_IMPLY(a_unprimed_empty, !r_primed, r_count == '0 && r_sum == '0, "unprimed window not empty")
    `PFD_IMPLY(a_lock_needs_full, r_lock != LOCK_BAD, w_full, "lock graded on partial window")
    `PFD_NEXT(a_write_then_loop, o_win_req.we, r_state == S_MULT, "window write not followed by PI step")

endmodule

[rtl/pps_frequency_discipline_unit.sv]
// PPS frequency discipline unit.
// Input channel (i_in_valid / o_in_stall, i_in_data): one transaction per event,
// either a PPS capture of the free-running oscillator counter or a fix-status update.
// Output channel (o_out_valid / i_out_stall, o_out_data): exactly one transaction per
// input event, carrying the DAC trim, a new-trim flag, the lock grade, the held fix
// state and the window drift sum.
// Fix updates and PPS pulses that do not close a sample span go from acceptance
// straight to the output register, and the next event is taken in the same cycle as
// the answer appears. A pulse that closes a span runs the PI step as a sequence through the
// window memory read/write, two gain multipliers and a divide-by-100 multiplier
// (S_DELTA, S_MULT, S_ACC, S_ABS, S_DIV, S_TRIM, S_EMIT); a skipped first sample goes S_DELTA, S_EMIT.
// One event is in flight at a time; the error window lives in a RAM with a registered read.
// Reset (synchronous, i_rst_n low) restores the register defaults, clears the fix,
// window, integral and lock grade, and sets the trim to mid-scale.
// A stalled result stays in the output register; the unit finishes the next event
// and then holds it until the output register frees, keeping o_in_stall high.
// Configuration registers sit on the APB port at byte addresses 0x0..0x10.
module pps_frequency_discipline_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  pfd_pkg::t_in_item          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output pfd_pkg::t_out_item         o_out_data,
    input  logic                       i_out_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pfd_pkg::*;

    t_cfg             w_cfg;
    t_trim_load       w_trim_load;
    t_win_req         w_win_req;
    logic [ERR_W-1:0] w_win_rdata;

    // Register file
    pfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (w_cfg),
        .o_trim_load (w_trim_load)
    );

    // Error window storage
    pfd_win_ram u_win_ram (
        .i_clk   (i_clk),
        .i_req   (w_win_req),
        .o_rdata (w_win_rdata)
    );

    // Sequencer and PI datapath
    pfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_trim_load (w_trim_load),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .o_win_req   (w_win_req),
        .i_win_rdata (w_win_rdata)
    );

endmodule

[dv/discipline_checker.sv]
module discipline_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  pfd_pkg::t_in_item          i_in_data,
    input  logic                       i_in_stall,
    input  logic                       i_out_valid,
    input  pfd_pkg::t_out_item         i_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [pfd_pkg::CFG_AW-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    import pfd_pkg::*;

    localparam longint DRIFT_TOP    = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint DRIFT_BOTTOM = -(longint'(1) <<< (SUM_W - 1));

    // Loop settings as last written on the register port
    logic [9:0]          kp;
    logic [9:0]          ki;
    logic [7:0]          span_pulses;
    logic [23:0]         nominal;

    // Loop state
    logic                fix_held;
    logic [7:0]          pulses_left;
    logic [STAMP_W-1:0]  prev_stamp;
    int                  win_count;
    logic signed [ERR_W-1:0] err_win [WINDOW_LEN];
    logic [ACC_W-1:0]    err_integral;
    logic [ACC_W-1:0]    trim_acc;
    logic [1:0]          grade;
    logic [TRIM_W-1:0]   dac_trim;

    t_out_item           expected_updates[$];
    t_out_item           want;
    int                  mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report(input string what, input longint got, input longint exp_val);
        $display("%0t: trim update check failed on %s: got 0x%0h, want 0x%0h",
                 $realtime, what, got, exp_val);
        mismatches++;
    endtask

    // Sum of the filled part of the error window
    function automatic longint window_total();
        longint s;
        s = 0;
        for (int k = 0; k < win_count && k < WINDOW_LEN; k++) s += err_win[k];
        return s;
    endfunction

    // One event through the PI loop; returns the update it must produce
    function automatic t_out_item discipline_step(input t_in_item ev);
        logic [31:0]             span;
        logic [31:0]             nominal_span;
        logic [31:0]             diff;
        logic [31:0]             pterm;
        logic [31:0]             iterm;
        logic signed [ERR_W-1:0] delta;
        logic signed [ERR_W-1:0] latest;
        longint                  prod;
        longint                  total;
        longint                  quot;
        logic                    wrote;
        t_out_item               res;
        wrote = 1'b0;
        if (ev.func == FUNC_FIX) begin
            if (ev.fix_valid != fix_held) begin
                fix_held = ev.fix_valid;
                // fix lost: restart the window and the integral
                if (!ev.fix_valid) begin
                    win_count    = -1;
                    pulses_left  = span_pulses;
                    err_integral = '0;
                    grade        = LOCK_BAD;
                end
            end
        end else if (!fix_held) begin
            prev_stamp = ev.timestamp;
        end else begin
            pulses_left = pulses_left - 8'd1;
            if (pulses_left == 8'd0) begin
                pulses_left  = span_pulses;
                span         = ev.timestamp - prev_stamp;
                prev_stamp   = ev.timestamp;
                nominal_span = span_pulses * nominal;
                diff         = span - nominal_span;
                delta        = diff[ERR_W-1:0];
                // first span after a fix is gained is thrown away
                if (win_count < 0) begin
                    win_count = 0;
                end else if (win_count < WINDOW_LEN) begin
                    err_win[win_count] = delta;
                    win_count++;
                end else begin
                    for (int k = 0; k < WINDOW_LEN - 1; k++) err_win[k] = err_win[k + 1];
                    err_win[WINDOW_LEN - 1] = delta;
                end

                total = window_total();
                if (total < 0) total = -total;
                if (win_count < WINDOW_LEN) grade = LOCK_BAD;
                else if (total < longint'(GRADE_BEST)) grade = LOCK_BEST;
                else if (total < longint'(GRADE_BETTER)) grade = LOCK_BETTER;
                else if (total < longint'(GRADE_GOOD)) grade = LOCK_GOOD;
                else grade = LOCK_BAD;

                // PI step on the newest error; accumulator holds trim x100
                if (win_count > 0) begin
                    latest       = err_win[win_count - 1];
                    err_integral = err_integral + {{(32 - ERR_W){latest[ERR_W-1]}}, latest};
                    prod         = longint'(latest) * longint'(kp);
                    pterm        = prod[31:0];
                    iterm        = err_integral * {22'd0, ki};
                    trim_acc     = trim_acc + pterm + iterm;
                    quot         = longint'(signed'(trim_acc)) / 100;
                    dac_trim     = quot[TRIM_W-1:0] + TRIM_MID;
                    wrote        = 1'b1;
                end
            end
        end

        total = window_total();
        if (total > DRIFT_TOP) total = DRIFT_TOP;
        if (total < DRIFT_BOTTOM) total = DRIFT_BOTTOM;

        res.dac_write    = wrote;
        res.dac_value    = dac_trim;
        res.lock_level   = grade;
        res.fix_status   = fix_held;
        res.window_drift = total[SUM_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp           = 10'd150;
            ki           = 10'd10;
            span_pulses  = COUNTDOWN_RST;
            nominal      = 24'd10000000;
            fix_held     = 1'b0;
            pulses_left  = COUNTDOWN_RST;
            prev_stamp   = '0;
            win_count    = -1;
            err_integral = '0;
            trim_acc     = '0;
            grade        = LOCK_BAD;
            dac_trim     = TRIM_MID;
            foreach (err_win[k]) err_win[k] = '0;
            expected_updates.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_PROP_GAIN:  kp = i_pwdata[9:0];
                    REG_INTEG_GAIN: ki = i_pwdata[9:0];
                    REG_SPAN_LEN:   span_pulses = i_pwdata[7:0];
                    REG_OSC_COUNTS: nominal = i_pwdata[23:0];
                    REG_INITIAL_TRIM: begin
                        dac_trim = i_pwdata[TRIM_W-1:0];
                        trim_acc = ({16'd0, dac_trim} - {16'd0, TRIM_MID}) * 32'd100;
                    end
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall)
                expected_updates.push_back(discipline_step(i_in_data));

            // compare each update transaction with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_updates.size() == 0) begin
                    report("update with nothing outstanding", i_out_data, 0);
                end else begin
                    want = expected_updates.pop_front();
                    if (i_out_data.dac_write !== want.dac_write)
                        report("dac_write", i_out_data.dac_write, want.dac_write);
                    if (i_out_data.dac_value !== want.dac_value)
                        report("dac_value", i_out_data.dac_value, want.dac_value);
                    if (i_out_data.lock_level !== want.lock_level)
                        report("lock_level", i_out_data.lock_level, want.lock_level);
                    if (i_out_data.fix_status !== want.fix_status)
                        report("fix_status", i_out_data.fix_status, want.fix_status);
                    if (i_out_data.window_drift !== want.window_drift)
                        report("window_drift", i_out_data.window_drift, want.window_drift);
                end
            end
        end
        o_pending <= expected_updates.size();
    end

endmodule

[dv/tb.sv]
module tb;
    import pfd_pkg::*;

    localparam int NUM_PHASES   = 16;
    localparam int PHASE_EVENTS = 108;
    localparam int QUIET_LIMIT  = 1000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_data   = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_item         o_out_data;
    logic              i_out_stall = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [CFG_AW-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                quiet = 0;
    bit                idling = 1'b0;
    bit                fix_now = 1'b0;
    logic [31:0]       next_stamp;
    logic [23:0]       nominal_now = 24'd10000000;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    pps_frequency_discipline_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    discipline_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Register write: setup cycle, then access until pready, then one idle cycle
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_OSC_COUNTS) nominal_now = value[23:0];
        @(posedge i_clk);
    endtask

    // Extremes a quarter of the time each, otherwise anywhere in range
    function automatic logic [31:0] pick_value(input logic [31:0] lo, input logic [31:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // One input transaction, with an optional idle burst ahead of it
    task automatic send_event(input t_in_item ev);
        if (idling && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // PPS capture one nominal second after the last, plus an error in counts
    task automatic send_pps(input int err);
        t_in_item ev;
        next_stamp   = next_stamp + nominal_now + err;
        ev.func      = FUNC_PPS;
        ev.timestamp = next_stamp;
        ev.fix_valid = 1'($urandom());
        send_event(ev);
    endtask

    // PPS capture at an arbitrary count; the stream continues from there
    task automatic send_stamp(input logic [31:0] stamp);
        t_in_item ev;
        next_stamp   = stamp;
        ev.func      = FUNC_PPS;
        ev.timestamp = stamp;
        ev.fix_valid = 1'($urandom());
        send_event(ev);
    endtask

    task automatic send_fix(input bit fix);
        t_in_item ev;
        ev.func      = FUNC_FIX;
        ev.timestamp = $urandom();
        ev.fix_valid = fix;
        fix_now      = fix;
        send_event(ev);
    endtask

    // Let every outstanding update come back before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Receiver stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("pps_frequency_discipline_unit: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int mag;
        int pick;
        next_stamp = $urandom();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fix handling under the reset settings
        idling = 1'b1;
        send_stamp(32'hFFFF_FFFF);
        send_stamp(32'h0000_0000);
        send_fix(1'b0);
        send_fix(1'b1);
        send_fix(1'b1);
        send_pps(0);
        send_fix(1'b0);
        drain();

        // Every span closes on one pulse; largest gains, clock and trim
        write_reg(REG_PROP_GAIN, 32'd1023);
        write_reg(REG_INTEG_GAIN, 32'd1023);
        write_reg(REG_SPAN_LEN, 32'd1);
        write_reg(REG_OSC_COUNTS, 32'hFF_FFFF);
        write_reg(REG_INITIAL_TRIM, 32'hFFFF);
        // a fix loss reloads the pulse countdown from the new span length
        send_fix(1'b1);
        send_fix(1'b0);
        send_fix(1'b1);
        send_stamp(32'hFFFF_FFF0);
        // fill the window with extreme errors, then slide it once
        for (int k = 0; k < WINDOW_LEN + 1; k++) send_pps((k % 2 == 1) ? -32768 : 32767);
        send_fix(1'b0);
        send_pps(0);

        // Random phases: mostly clean PPS streams under a held fix
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            idling = (phase < NUM_PHASES - 2) && (phase % 4 != 1);
            write_reg(REG_PROP_GAIN, pick_value(0, 1023));
            write_reg(REG_INTEG_GAIN, pick_value(0, 1023));
            if (phase == 5) write_reg(REG_SPAN_LEN, 32'd255);
            else if ($urandom_range(0, 7) == 0) write_reg(REG_SPAN_LEN, pick_value(1, 255));
            else write_reg(REG_SPAN_LEN, $urandom_range(1, 4));
            write_reg(REG_OSC_COUNTS, pick_value(1, 32'hFF_FFFF));
            if (phase % 2 == 0) write_reg(REG_INITIAL_TRIM, pick_value(0, 32'hFFFF));

            case ($urandom_range(0, 5))
                0:       mag = 0;
                1:       mag = 2;
                2:       mag = 6;
                3:       mag = 40;
                4:       mag = 400;
                default: mag = 32768;
            endcase

            for (int n = 0; n < PHASE_EVENTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) send_fix(1'b0);
                else if (pick < 5) send_fix(fix_now);
                else if (pick < 8) send_stamp($urandom());
                else if (!fix_now) send_fix(1'b1);
                else send_pps(int'($urandom_range(0, 2 * mag)) - mag);
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("pps_frequency_discipline_unit: match");
        end else begin
            $display("pps_frequency_discipline_unit: mismatch");
        end
        $finish;
    end

endmodule
